FILE: sv/gwm_pkg.sv
`timescale 1ns / 1ps

package gwm_pkg;

   localparam logic [1:0] OP_CLEAR  = 2'd0;
   localparam logic [1:0] OP_APPEND = 2'd1;
   localparam logic [1:0] OP_TEXT   = 2'd2;
   localparam logic [1:0] OP_END    = 2'd3;

   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_QUEST = 8'h3F;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] CASE_OFFSET = 8'h20;

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] char_in;
   } req_type;

   typedef struct packed {
      logic matched;
      logic overflow;
   } rsp_type;

   typedef struct packed {
      logic       rearm;
      logic       step;
      logic       wr;
      logic [7:0] ch;
   } gwm_ctl_type;

   function automatic logic [7:0] fold_char(input logic [7:0] c);
      if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
         return c + CASE_OFFSET;
      end
      return c;
   endfunction

endpackage

FILE: sv/gwm_closure.sv
`timescale 1ns / 1ps

module gwm_closure #(
   parameter int N = 65
) (
   input  logic [N-1:0] gen,
   input  logic [N-1:0] prop,
   output logic [N-1:0] closed
);

   logic [N-1:0] open_bits;
   logic [N-1:0] sum;

   // carry from each active position ripples through the following star run
   assign open_bits = prop & ~gen;
   assign sum       = open_bits + (gen << 1);
   assign closed    = gen | (open_bits & ~sum);

endmodule

FILE: sv/gwm_cell.sv
`timescale 1ns / 1ps

module gwm_cell #(
   parameter int IDX   = 0,
   parameter int LEN_W = 7
) (
   input  logic               clock,
   input  logic               reset,
   input  gwm_pkg::gwm_ctl_type ctl,
   input  logic [LEN_W-1:0]   len,
   input  logic               closed,
   input  logic               adv_in,
   output logic               adv_out,
   output logic               star_out,
   output logic               raw_out,
   output logic               end_hit
);

   import gwm_pkg::*;

   localparam logic [LEN_W-1:0] MY_POS = LEN_W'(IDX);
   localparam logic             RAW_RESET = (IDX == 0);

   logic [7:0] char_ff;
   logic       raw_ff;
   logic       raw_in;
   logic       in_pattern;
   logic       is_star;
   logic       is_quest;
   logic       hit;

   assign in_pattern = MY_POS < len;
   assign is_star    = in_pattern && (char_ff == CH_STAR);
   assign is_quest   = in_pattern && (char_ff == CH_QUEST);
   assign hit        = in_pattern && !is_star && (is_quest || (char_ff == ctl.ch));

   assign adv_out  = closed & hit;
   assign star_out = is_star;
   assign raw_out  = raw_ff;
   assign end_hit  = closed & (len == MY_POS);

   always_comb begin
      raw_in = raw_ff;
      if (ctl.rearm) begin
         raw_in = RAW_RESET;
      end else if (ctl.step) begin
         raw_in = (closed & is_star) | adv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_ff <= RAW_RESET;
      end else begin
         raw_ff <= raw_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr && (len == MY_POS)) begin
         char_ff <= ctl.ch;
      end
   end

endmodule

FILE: sv/glob_wildcard_matcher.sv
`timescale 1ns / 1ps

// Case-insensitive glob matcher ('*' any run, '?' one byte, A-Z folded).
// Send a clear item, then one append item per pattern byte (bytes past
// PAT_LEN are dropped and reported as overflow), then text bytes and an
// end-of-text item, which returns one result item with matched and overflow
// and rearms the matcher for the next text. A new item can be accepted on
// every clock unless both entries of the two-entry output buffer are full;
// each pattern position is a cell that holds its byte and active bit and
// passes an advance bit to the next cell, and closure across runs of stars
// is done in one carry chain of PAT_LEN+1 bits, which sets the cycle time.
// The result is registered and valid the cycle after the end-of-text item
// if the output entry is free or taken, else it waits in the second entry.
module glob_wildcard_matcher #(
   parameter int PAT_LEN = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  gwm_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output gwm_pkg::rsp_type rsp_data
);

   import gwm_pkg::*;

   localparam int LEN_W = $clog2(PAT_LEN + 1);
   localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(PAT_LEN);

   logic             req_fire;
   gwm_ctl_type      ctl;
   logic [LEN_W-1:0] len_ff, len_in;
   logic             ovf_ff, ovf_in;
   logic             raw_top_ff, raw_top_in;
   logic [PAT_LEN:0] raw;
   logic [PAT_LEN:0] prop;
   logic [PAT_LEN:0] closed;
   logic [PAT_LEN:0] adv;
   logic [PAT_LEN:0] end_hit;
   logic             push;
   logic             pop;
   rsp_type          new_rsp;
   rsp_type          out_ff, out_in;
   rsp_type          skid_ff, skid_in;
   logic             out_v_ff, out_v_in;
   logic             skid_v_ff, skid_v_in;

   assign req_ready = !skid_v_ff;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      ctl.rearm = req_fire && (req_data.opcode == OP_CLEAR || req_data.opcode == OP_APPEND
                               || req_data.opcode == OP_END);
      ctl.step  = req_fire && (req_data.opcode == OP_TEXT);
      ctl.wr    = req_fire && (req_data.opcode == OP_APPEND) && (len_ff < LEN_MAX);
      ctl.ch    = fold_char(req_data.char_in);
   end

   assign adv[0]  = 1'b0;
   assign prop[0] = 1'b0;

   for (genvar i = 0; i < PAT_LEN; i++) begin : g_cell
      gwm_cell #(
         .IDX   (i),
         .LEN_W (LEN_W)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .len      (len_ff),
         .closed   (closed[i]),
         .adv_in   (adv[i]),
         .adv_out  (adv[i+1]),
         .star_out (prop[i+1]),
         .raw_out  (raw[i]),
         .end_hit  (end_hit[i])
      );
   end

   assign raw[PAT_LEN]     = raw_top_ff;
   assign end_hit[PAT_LEN] = closed[PAT_LEN] & (len_ff == LEN_MAX);

   gwm_closure #(
      .N (PAT_LEN + 1)
   ) u_closure (
      .gen    (raw),
      .prop   (prop),
      .closed (closed)
   );

   always_comb begin
      len_in     = len_ff;
      ovf_in     = ovf_ff;
      raw_top_in = raw_top_ff;
      if (ctl.rearm) begin
         raw_top_in = 1'b0;
      end else if (ctl.step) begin
         raw_top_in = adv[PAT_LEN];
      end
      if (req_fire) begin
         unique case (req_data.opcode)
            OP_CLEAR: begin
               len_in = '0;
               ovf_in = 1'b0;
            end
            OP_APPEND: begin
               if (len_ff < LEN_MAX) begin
                  len_in = len_ff + LEN_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign push             = req_fire && (req_data.opcode == OP_END);
   assign pop              = out_v_ff && rsp_ready;
   assign new_rsp.matched  = |end_hit;
   assign new_rsp.overflow = ovf_ff;

   always_comb begin
      out_in    = out_ff;
      out_v_in  = out_v_ff;
      skid_in   = skid_ff;
      skid_v_in = skid_v_ff;
      if (skid_v_ff) begin
         if (pop) begin
            out_in    = skid_ff;
            skid_v_in = 1'b0;
         end
      end else if (push) begin
         if (!out_v_ff || pop) begin
            out_in   = new_rsp;
            out_v_in = 1'b1;
         end else begin
            skid_in   = new_rsp;
            skid_v_in = 1'b1;
         end
      end else if (pop) begin
         out_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff     <= '0;
         ovf_ff     <= 1'b0;
         raw_top_ff <= 1'b0;
         out_v_ff   <= 1'b0;
         skid_v_ff  <= 1'b0;
      end else begin
         len_ff     <= len_in;
         ovf_ff     <= ovf_in;
         raw_top_ff <= raw_top_in;
         out_v_ff   <= out_v_in;
         skid_v_ff  <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

`ifndef SYNTHESIS
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid entry held without output entry");

   a_len_in_range: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_MAX)
      else $error("pattern length past capacity");

   a_clear_rearms: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_data.opcode == OP_CLEAR) |=>
         (raw == {{PAT_LEN{1'b0}}, 1'b1}) && !ovf_ff)
      else $error("clear did not rearm matcher");
`endif

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb;
   import gwm_pkg::*;

   localparam int PAT_LEN     = 64;
   localparam int RAND_ITEMS  = 1950;
   localparam int HOLD_CYCLES = 300;
   localparam int STALL_LIMIT = 4000;
   localparam int CALM_ITEMS  = 200;
   localparam bit TYPED = 1'b1;
   localparam bit PRED  = 1'b0;

   typedef struct packed {
      req_type item;
      logic    typed;
      rsp_type want;
   } dir_row_type;

   localparam int N_DIR = 29;

   // opcode, byte, typed or predicted, matched, overflow
   dir_row_type dir_rows [0:N_DIR-1] = '{
      {OP_END,    8'hFF,    TYPED, 1'b1, 1'b0},
      {OP_TEXT,   8'h00,    PRED,  1'b0, 1'b0},
      {OP_END,    8'h00,    TYPED, 1'b0, 1'b0},
      {OP_CLEAR,  8'hFF,    PRED,  1'b0, 1'b0},
      {OP_APPEND, 8'h41,    PRED,  1'b0, 1'b0},
      {OP_APPEND, CH_STAR,  PRED,  1'b0, 1'b0},
      {OP_APPEND, CH_QUEST, PRED,  1'b0, 1'b0},
      {OP_APPEND, 8'h00,    PRED,  1'b0, 1'b0},
      {OP_APPEND, 8'hFF,    PRED,  1'b0, 1'b0},
      {OP_TEXT,   8'h61,    PRED,  1'b0, 1'b0},
      {OP_TEXT,   8'h78,    PRED,  1'b0, 1'b0},
      {OP_TEXT,   8'h5A,    PRED,  1'b0, 1'b0},
      {OP_TEXT,   8'h00,    PRED,  1'b0, 1'b0},
      {OP_TEXT,   8'hFF,    PRED,  1'b0, 1'b0},
      {OP_END,    8'h55,    PRED,  1'b0, 1'b0},
      {OP_TEXT,   8'h61,    PRED,  1'b0, 1'b0},
      {OP_APPEND, 8'h51,    PRED,  1'b0, 1'b0},
      {OP_END,    8'h00,    PRED,  1'b0, 1'b0},
      {OP_CLEAR,  8'h00,    PRED,  1'b0, 1'b0},
      {OP_APPEND, 8'h7A,    PRED,  1'b0, 1'b0},
      {OP_TEXT,   8'h5A,    PRED,  1'b0, 1'b0},
      {OP_END,    8'hFF,    PRED,  1'b0, 1'b0},
      {OP_CLEAR,  8'h2A,    PRED,  1'b0, 1'b0},
      {OP_APPEND, 8'hC1,    PRED,  1'b0, 1'b0},
      {OP_TEXT,   8'hE1,    PRED,  1'b0, 1'b0},
      {OP_END,    8'h00,    PRED,  1'b0, 1'b0},
      {OP_CLEAR,  8'h00,    PRED,  1'b0, 1'b0},
      {OP_APPEND, CH_STAR,  PRED,  1'b0, 1'b0},
      {OP_END,    8'h00,    TYPED, 1'b1, 1'b0}
   };

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   logic [7:0]       pat_mem [PAT_LEN];
   int               pat_len = 0;
   logic [PAT_LEN:0] reach = {{PAT_LEN{1'b0}}, 1'b1};
   logic             ovf_seen = 1'b0;

   rsp_type    pending_matches [$];
   logic [7:0] text_buf [$];

   int items_sent = 0;
   int results_seen = 0;
   int matched_seen = 0;
   int overflow_seen = 0;
   int errors = 0;
   int idle_pct = 0;
   bit calm = 1'b0;
   bit hold_request = 1'b0;

   glob_wildcard_matcher #(.PAT_LEN(PAT_LEN)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [7:0] to_lower(input logic [7:0] c);
      return (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? (c | CASE_OFFSET) : c;
   endfunction

   function automatic void spread_stars();
      for (int i = 0; i < pat_len; i++) begin
         if (reach[i] && pat_mem[i] == CH_STAR) begin
            reach[i+1] = 1'b1;
         end
      end
   endfunction

   function automatic void restart_text();
      reach = {{PAT_LEN{1'b0}}, 1'b1};
      spread_stars();
   endfunction

   function automatic bit glob_step(input req_type it, output rsp_type res);
      logic [PAT_LEN:0] nxt;
      res = '0;
      case (it.opcode)
         OP_CLEAR: begin
            pat_len = 0;
            ovf_seen = 1'b0;
            restart_text();
         end
         OP_APPEND: begin
            if (pat_len < PAT_LEN) begin
               pat_mem[pat_len] = it.char_in;
               pat_len++;
            end else begin
               ovf_seen = 1'b1;
            end
            restart_text();
         end
         OP_TEXT: begin
            nxt = '0;
            for (int i = 0; i < pat_len; i++) begin
               if (reach[i]) begin
                  if (pat_mem[i] == CH_STAR) begin
                     nxt[i] = 1'b1;
                  end else if (pat_mem[i] == CH_QUEST ||
                               to_lower(pat_mem[i]) == to_lower(it.char_in)) begin
                     nxt[i+1] = 1'b1;
                  end
               end
            end
            reach = nxt;
            spread_stars();
         end
         default: begin
            res.matched = reach[pat_len];
            res.overflow = ovf_seen;
            restart_text();
            return 1'b1;
         end
      endcase
      return 1'b0;
   endfunction

   function automatic logic [7:0] rand_letter();
      logic [7:0] c;
      c = 8'h61 + 8'($urandom_range(0, 3));
      return $urandom_range(1) ? (c ^ CASE_OFFSET) : c;
   endfunction

   function automatic logic [7:0] rand_pat_byte();
      int r;
      r = $urandom_range(99);
      if (r < 22) begin
         return CH_STAR;
      end else if (r < 35) begin
         return CH_QUEST;
      end else if (r < 85) begin
         return rand_letter();
      end
      return 8'($urandom_range(255));
   endfunction

   // build a text that tends to match the given pattern, then maybe spoil it
   function automatic void make_text(input logic [7:0] pat [$]);
      logic [7:0] b;
      text_buf.delete();
      foreach (pat[i]) begin
         b = pat[i];
         if (b == CH_STAR) begin
            repeat ($urandom_range(0, 3)) begin
               text_buf.push_back($urandom_range(3) == 0 ? 8'($urandom_range(255))
                                                          : rand_letter());
            end
         end else if (b == CH_QUEST) begin
            text_buf.push_back(8'($urandom_range(255)));
         end else if (to_lower(b) >= 8'h61 && to_lower(b) <= 8'h7A && $urandom_range(1)) begin
            text_buf.push_back(b ^ CASE_OFFSET);
         end else begin
            text_buf.push_back(b);
         end
      end
      if ($urandom_range(99) < 30) begin
         case ($urandom_range(2))
            0: text_buf.push_back(rand_letter());
            1: if (text_buf.size() > 0) text_buf.delete(text_buf.size() - 1);
            default: if (text_buf.size() > 0) begin
               text_buf[$urandom_range(text_buf.size() - 1)] = rand_letter();
            end
         endcase
      end
   endfunction

   task automatic offer(input req_type it, input bit typed = 1'b0,
                        input rsp_type want = '0);
      rsp_type res;
      if (!calm && $urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= it;
      do @(posedge clock); while (!req_ready);
      if (glob_step(it, res)) begin
         pending_matches.push_back(typed ? want : res);
      end
      items_sent++;
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_matches.size() != 0) @(negedge clock);
   endtask

   task automatic pattern_session(input int seq_no);
      logic [7:0] pat [$];
      logic [7:0] b;
      int n;
      if (seq_no == 0) begin
         n = PAT_LEN + 2;
      end else if ($urandom_range(99) < 3) begin
         n = $urandom_range(PAT_LEN - 2, PAT_LEN + 3);
      end else begin
         n = $urandom_range(0, 8);
      end
      offer({OP_CLEAR, 8'($urandom_range(255))});
      repeat (n) begin
         b = rand_pat_byte();
         if (pat.size() < PAT_LEN) pat.push_back(b);
         offer({OP_APPEND, b});
      end
      repeat ($urandom_range(1, 4)) begin
         make_text(pat);
         foreach (text_buf[i]) begin
            if ($urandom_range(99) < 2) begin
               b = rand_pat_byte();
               if (pat.size() < PAT_LEN) pat.push_back(b);
               offer({OP_APPEND, b});
            end
            offer({OP_TEXT, text_buf[i]});
         end
         offer({OP_END, 8'($urandom_range(255))});
      end
   endtask

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         matched_seen += rsp_data.matched;
         overflow_seen += rsp_data.overflow;
         if (pending_matches.size() == 0) begin
            $error("unexpected result: matched %0b overflow %0b",
                   rsp_data.matched, rsp_data.overflow);
            errors++;
         end else begin
            want = pending_matches.pop_front();
            if (rsp_data.matched !== want.matched) begin
               $error("matched: expected %0b, actual %0b", want.matched, rsp_data.matched);
               errors++;
            end
            if (rsp_data.overflow !== want.overflow) begin
               $error("overflow: expected %0b, actual %0b", want.overflow, rsp_data.overflow);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      int quiet;
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet = 0;
      end else begin
         quiet++;
         if (quiet >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   initial begin : rsp_side
      wait (!reset);
      @(negedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else if (!calm && $urandom_range(99) < 25) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(negedge clock);
         end
      end
   end

   initial begin : req_side
      int seq_no;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      idle_pct = 15;
      for (int i = 0; i < N_DIR; i++) begin
         offer(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
      end

      seq_no = 0;
      while (items_sent < N_DIR + RAND_ITEMS) begin
         calm = (items_sent > N_DIR + RAND_ITEMS - CALM_ITEMS);
         case ($urandom_range(2))
            0: idle_pct = 0;
            1: idle_pct = 10;
            default: idle_pct = 35;
         endcase
         if (seq_no == 30) begin
            idle_pct = 0;
            hold_request = 1'b1;
            repeat (16) begin
               offer({OP_TEXT, 8'($urandom_range(255))});
               offer({OP_END, 8'($urandom_range(255))});
            end
            drain_results();
         end else if (seq_no > 0 && $urandom_range(99) < 12) begin
            repeat ($urandom_range(1, 10)) begin
               offer({2'($urandom_range(3)), 8'($urandom_range(255))});
            end
         end else begin
            pattern_session(seq_no);
         end
         seq_no++;
      end

      drain_results();
      repeat (8) @(posedge clock);
      $display("summary: %0d items in %0d sessions, %0d results (%0d matched, %0d overflow)",
               items_sent, seq_no, results_seen, matched_seen, overflow_seen);
      if (errors == 0 && pending_matches.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

FILE: files.f
sv/gwm_pkg.sv
sv/gwm_closure.sv
sv/gwm_cell.sv
sv/glob_wildcard_matcher.sv
dv/tb.sv
